// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL. Each macro expects signals named clk and rst_n
// in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sgbs_pkg.sv =====
`timescale 1ns / 1ps

package sgbs_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 22;

    localparam int GAIN_LEVEL_W  = 17;
    localparam int BALANCE_W     = 16;
    localparam int COEFF_W       = 16;
    localparam int FACTOR_W      = 15;
    localparam int TPROD_W       = GAIN_LEVEL_W + FACTOR_W;
    localparam int TGT_FRAC_BITS = 28;
    localparam int PEAK_W        = 24;
    localparam int COUNT_W       = 32;
    localparam int CFG_DATA_W    = 17;
    localparam int CFG_INDEX_W   = 3;
    localparam int SNAP_LSB      = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_LEVEL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MUTE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MONO_MIX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF      = 3'd4;

    localparam logic [GAIN_LEVEL_W-1:0] GAIN_LEVEL_RST = 17'd16384;
    localparam logic [GAIN_LEVEL_W-1:0] GAIN_MAX       = 17'd65536;
    localparam logic [COEFF_W-1:0]      COEFF_RST      = 16'd273;
    localparam logic signed [BALANCE_W-1:0] BAL_POS    = 16'sd16384;
    localparam logic signed [BALANCE_W-1:0] BAL_NEG    = -16'sd16384;
    localparam logic [FACTOR_W-1:0]     FACTOR_ONE     = 15'd16384;

    typedef struct packed {
        logic take;
        logic tgt;
        logic step;
        logic upd;
        logic mul;
        logic rnd;
        logic last;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic last;
        logic mono;
    } merge_ctrl_t;

endpackage

// ===== rtl/sgbs_lane.sv =====
`timescale 1ns / 1ps

module sgbs_lane #(
    parameter int SAMPLE_BITS    = sgbs_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = sgbs_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sgbs_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic [sgbs_pkg::GAIN_LEVEL_W-1:0]    gain_level,
    input  logic [sgbs_pkg::FACTOR_W-1:0]        factor,
    input  logic [sgbs_pkg::COEFF_W-1:0]         coeff,
    output logic signed [SAMPLE_BITS-1:0]        y
);
    import sgbs_pkg::*;

    localparam int GAIN_W = GAIN_FRAC_BITS + 3;
    localparam int SP_W   = GAIN_W + COEFF_W;
    localparam int MP_W   = SAMPLE_BITS + GAIN_W + 1;
    localparam int TW_W   = TPROD_W + 2;
    localparam int SHR    = (GAIN_FRAC_BITS <= TGT_FRAC_BITS) ?
                            (TGT_FRAC_BITS - GAIN_FRAC_BITS) : 0;
    localparam int SHL    = (GAIN_FRAC_BITS > TGT_FRAC_BITS) ?
                            (GAIN_FRAC_BITS - TGT_FRAC_BITS) : 0;

    localparam logic [SP_W:0] STEP_BIAS = (SP_W + 1)'((64'd1 << COEFF_W) - 64'd1);
    localparam logic signed [GAIN_W:0] SNAP_P = (GAIN_W + 1)'(SNAP_LSB);
    localparam logic signed [GAIN_W:0] SNAP_N = -SNAP_P;
    localparam logic signed [MP_W-1:0] RND_BIAS = MP_W'(64'sd1 <<< (GAIN_FRAC_BITS - 1));
    localparam logic signed [MP_W-1:0] SAT_HI =
        MP_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [MP_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [GAIN_W-1:0]             target_reg;
    logic [GAIN_W-1:0]             gain_reg;
    logic [SP_W-1:0]               sprod_reg;
    logic                          down_reg;
    logic signed [MP_W-1:0]        mprod_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;

    logic [TPROD_W-1:0]            tprod;
    logic [TW_W-1:0]               tshift;
    logic [GAIN_W-1:0]             target_next;
    logic                          down;
    logic [GAIN_W-1:0]             mag;
    logic [SP_W-1:0]               sprod_next;
    logic [SP_W:0]                 round_sum;
    logic [GAIN_W-1:0]             step;
    logic [GAIN_W-1:0]             gain_next;
    logic signed [GAIN_W:0]        snap_diff;
    logic                          near;
    logic signed [MP_W-1:0]        mprod_next;
    logic signed [MP_W-1:0]        rsh;
    logic signed [SAMPLE_BITS-1:0] y_next;

    always_comb
    begin
        tprod       = TPROD_W'(gain_level) * TPROD_W'(factor);
        tshift      = (TW_W'(tprod) << SHL) >> SHR;
        target_next = tshift[GAIN_W-1:0];

        down       = gain_reg > target_reg;
        mag        = down ? (gain_reg - target_reg) : (target_reg - gain_reg);
        sprod_next = SP_W'(mag) * SP_W'(coeff);

        // The step is rounded up so that any nonzero coefficient keeps the gain moving toward its target.
        round_sum = (SP_W + 1)'(sprod_reg) + STEP_BIAS;
        step      = round_sum[SP_W-1:COEFF_W];
        gain_next = down_reg ? (gain_reg - step) : (gain_reg + step);

        snap_diff = $signed({1'b0, target_reg}) - $signed({1'b0, gain_reg});
        near      = (snap_diff <= SNAP_P) && (snap_diff >= SNAP_N);

        mprod_next = MP_W'(sample_reg) * MP_W'($signed({1'b0, gain_reg}));

        rsh = (mprod_reg + RND_BIAS) >>> GAIN_FRAC_BITS;
        if (rsh > SAT_HI)
        begin
            y_next = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rsh < SAT_LO)
        begin
            y_next = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_next = rsh[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            gain_reg <= gain_next;
        end
        else if (ctrl.mul && ctrl.last && near)
        begin
            gain_reg <= target_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            sample_reg <= sample;
        end
        if (ctrl.tgt)
        begin
            target_reg <= target_next;
        end
        if (ctrl.step)
        begin
            sprod_reg <= sprod_next;
            down_reg  <= down;
        end
        if (ctrl.mul)
        begin
            mprod_reg <= mprod_next;
        end
        if (ctrl.rnd)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/sgbs_merge.sv =====
`timescale 1ns / 1ps

module sgbs_merge #(
    parameter int SAMPLE_BITS = sgbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sgbs_pkg::merge_ctrl_t             ctrl,
    input  logic signed [SAMPLE_BITS-1:0]     y_left,
    input  logic signed [SAMPLE_BITS-1:0]     y_right,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [SAMPLE_BITS-1:0]     left_out,
    output logic signed [SAMPLE_BITS-1:0]     right_out,
    output logic                              buffer_end,
    output logic [sgbs_pkg::PEAK_W-1:0]       peak_level,
    output logic [sgbs_pkg::COUNT_W-1:0]      buffers_completed
);
    import sgbs_pkg::*;

    localparam int PK_W = (SAMPLE_BITS > PEAK_W) ? SAMPLE_BITS : PEAK_W;

    function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic signed [SAMPLE_BITS-1:0] v);
        return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
    endfunction

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic                          end_reg;
    logic [PEAK_W-1:0]             peak_out_reg;
    logic [PK_W-1:0]               peak_reg;
    logic [COUNT_W-1:0]            count_reg;

    logic signed [SAMPLE_BITS:0]   mono_sum;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] ro;
    logic [SAMPLE_BITS-1:0]        mag_l;
    logic [SAMPLE_BITS-1:0]        mag_r;
    logic [SAMPLE_BITS-1:0]        pk;
    logic [PK_W-1:0]               pk_max;

    always_comb
    begin
        mono_sum = (SAMPLE_BITS + 1)'(y_left) + (SAMPLE_BITS + 1)'(y_right);
        lo       = ctrl.mono ? mono_sum[SAMPLE_BITS:1] : y_left;
        ro       = ctrl.mono ? '0 : y_right;
        mag_l    = mag_of(lo);
        mag_r    = mag_of(ro);
        pk       = (ctrl.mono || (mag_l > mag_r)) ? mag_l : mag_r;
        pk_max   = (PK_W'(pk) > peak_reg) ? PK_W'(pk) : peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            count_reg     <= '0;
        end
        else if (ctrl.load)
        begin
            out_valid_reg <= 1'b1;
            peak_reg      <= ctrl.last ? '0 : pk_max;
            count_reg     <= count_reg + COUNT_W'(ctrl.last);
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            left_reg     <= lo;
            right_reg    <= ro;
            end_reg      <= ctrl.last;
            peak_out_reg <= ctrl.last ? pk_max[PEAK_W-1:0] : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign left_out          = left_reg;
    assign right_out         = right_reg;
    assign buffer_end        = end_reg;
    assign peak_level        = peak_out_reg;
    assign buffers_completed = count_reg;

endmodule

// ===== rtl/stereo_gain_balance_smoother_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Stereo gain, balance and mute with smoothed per-channel gains and a buffer peak meter.
// Input items are stereo frames on in_valid/in_ready with a last_in_buffer mark; results
// leave on out_valid/out_ready, one result item for every input item, in order.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must write them only while no item is
// in flight, as the block itself does not enforce it. A left and a right lane each form their target gain, take
// one smoothing step, apply the gain and round; a merge stage forms the mono mix, the peak and the buffer count.
// One item is in flight at a time and the next may be accepted in the cycle its result
// is loaded. The sequencer steps through the target multiply, the smoothing multiply,
// the gain update, the sample multiply, rounding and merge, and out_valid rises when
// the merge step loads the result into the output register.
// While a result waits in the output register and out_ready is low, an item that
// reaches the merge step holds there and in_ready stays low.
// Reset loads the register defaults, sets both running gains to zero so that the
// output fades in, clears the peak and the buffer count and empties the output.
module stereo_gain_balance_smoother_core #(
    parameter int SAMPLE_BITS    = sgbs_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = sgbs_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sgbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sgbs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       right_sample,
    input  logic                                last_in_buffer,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out,
    output logic                                buffer_end,
    output logic [sgbs_pkg::PEAK_W-1:0]         peak_level,
    output logic [sgbs_pkg::COUNT_W-1:0]        buffers_completed
);
    import sgbs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TGT  = 7'b0000010,
        S_STEP = 7'b0000100,
        S_UPD  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_RND  = 7'b0100000,
        S_MRG  = 7'b1000000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic                          last_reg;

    logic [GAIN_LEVEL_W-1:0]       gain_level_reg;
    logic signed [BALANCE_W-1:0]   balance_reg;
    logic                          mute_reg;
    logic                          mono_reg;
    logic [COEFF_W-1:0]            coeff_reg;

    logic [GAIN_LEVEL_W-1:0]       gain_eff;
    logic signed [BALANCE_W-1:0]   bal_cl;
    logic [FACTOR_W-1:0]           factor_l;
    logic [FACTOR_W-1:0]           factor_r;

    logic                          accept;
    logic                          mrg_go;
    lane_ctrl_t                    lane_ctrl;
    merge_ctrl_t                   merge_ctrl;
    logic signed [SAMPLE_BITS-1:0] y_left;
    logic signed [SAMPLE_BITS-1:0] y_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_level_reg <= GAIN_LEVEL_RST;
            balance_reg    <= '0;
            mute_reg       <= 1'b0;
            mono_reg       <= 1'b0;
            coeff_reg      <= COEFF_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_LEVEL: gain_level_reg <= cfg_data[GAIN_LEVEL_W-1:0];
                REG_BALANCE:    balance_reg    <= cfg_data[BALANCE_W-1:0];
                REG_MUTE:       mute_reg       <= cfg_data[0];
                REG_MONO_MIX:   mono_reg       <= cfg_data[0];
                REG_COEFF:      coeff_reg      <= cfg_data[COEFF_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (mute_reg)
        begin
            gain_eff = '0;
        end
        else
        begin
            gain_eff = (gain_level_reg > GAIN_MAX) ? GAIN_MAX : gain_level_reg;
        end

        if (balance_reg > BAL_POS)
        begin
            bal_cl = BAL_POS;
        end
        else if (balance_reg < BAL_NEG)
        begin
            bal_cl = BAL_NEG;
        end
        else
        begin
            bal_cl = balance_reg;
        end

        factor_l = (bal_cl > 0) ? (FACTOR_ONE - FACTOR_W'(bal_cl)) : FACTOR_ONE;
        factor_r = (bal_cl < 0) ? (FACTOR_ONE - FACTOR_W'(-bal_cl)) : FACTOR_ONE;
    end

    assign mrg_go   = (state_reg == S_MRG) && (!out_valid || out_ready);
    assign in_ready = (state_reg == S_IDLE) || mrg_go;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = in_valid ? S_TGT : S_IDLE;
            S_TGT:   state_next = S_STEP;
            S_STEP:  state_next = S_UPD;
            S_UPD:   state_next = S_MUL;
            S_MUL:   state_next = S_RND;
            S_RND:   state_next = S_MRG;
            S_MRG:
            begin
                if (mrg_go)
                begin
                    state_next = in_valid ? S_TGT : S_IDLE;
                end
                else
                begin
                    state_next = S_MRG;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_in_buffer;
        end
    end

    always_comb
    begin
        lane_ctrl.take  = accept;
        lane_ctrl.tgt   = state_reg == S_TGT;
        lane_ctrl.step  = state_reg == S_STEP;
        lane_ctrl.upd   = state_reg == S_UPD;
        lane_ctrl.mul   = state_reg == S_MUL;
        lane_ctrl.rnd   = state_reg == S_RND;
        lane_ctrl.last  = last_reg;
        merge_ctrl.load = mrg_go;
        merge_ctrl.last = last_reg;
        merge_ctrl.mono = mono_reg;
    end

    sgbs_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .sample     (left_sample),
        .gain_level (gain_eff),
        .factor     (factor_l),
        .coeff      (coeff_reg),
        .y          (y_left)
    );

    sgbs_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .sample     (right_sample),
        .gain_level (gain_eff),
        .factor     (factor_r),
        .coeff      (coeff_reg),
        .y          (y_right)
    );

    sgbs_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (merge_ctrl),
        .y_left            (y_left),
        .y_right           (y_right),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .left_out          (left_out),
        .right_out         (right_out),
        .buffer_end        (buffer_end),
        .peak_level        (peak_level),
        .buffers_completed (buffers_completed)
    );

    `ASSERT_NXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "second item taken while one is in flight")
    `ASSERT_NXT(a_merge_holds_on_stall, (state_reg == S_MRG) && out_valid && !out_ready, state_reg == S_MRG, "merge step left while the output was stalled")
    `ASSERT_IMP(a_count_on_buffer_end, !$stable(buffers_completed), $past(mrg_go) && $past(last_reg), "buffer count moved without a closing item")

endmodule

// ===== sim/stereo_gain_balance_smoother_core_test.sv =====
`timescale 1ns / 1ps

module stereo_gain_balance_smoother_core_test;

    import sgbs_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int GF = GAIN_FRAC_BITS_DEF;
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct {
        logic signed [SW-1:0] left_out;
        logic signed [SW-1:0] right_out;
        logic                 closed;
        logic [PEAK_W-1:0]    peak;
        logic [COUNT_W-1:0]   count;
    } frame_result_t;

    typedef enum {RX_ALWAYS, RX_PATTERN, RX_SPARSE, RX_DENSE} rx_mode_t;

    class balance_scoreboard;
        logic [GAIN_LEVEL_W-1:0]     gain_level;
        logic signed [BALANCE_W-1:0] balance;
        logic                        mute;
        logic                        mono;
        logic [COEFF_W-1:0]          coeff;
        longint                      left_gain;
        longint                      right_gain;
        longint                      peak_acc;
        logic [COUNT_W-1:0]          buffer_count;
        frame_result_t               pending_frames[$];
        int                          errors;

        function new();
            gain_level   = GAIN_LEVEL_RST;
            balance      = '0;
            mute         = 1'b0;
            mono         = 1'b0;
            coeff        = COEFF_RST;
            left_gain    = 0;
            right_gain   = 0;
            peak_acc     = 0;
            buffer_count = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_LEVEL: gain_level = data;
                REG_BALANCE:    balance = data[BALANCE_W-1:0];
                REG_MUTE:       mute = data[0];
                REG_MONO_MIX:   mono = data[0];
                REG_COEFF:      coeff = data[COEFF_W-1:0];
                default:        ;
            endcase
        endfunction

        function longint target_gain(longint factor);
            longint g;
            g = (gain_level > GAIN_MAX) ? GAIN_MAX : gain_level;
            if (mute)
                g = 0;
            return (g * factor) >>> (TGT_FRAC_BITS - GF);
        endfunction

        function longint step_toward(longint cur, longint tgt);
            longint diff;
            longint mag;
            longint stride;
            diff = tgt - cur;
            mag = (diff < 0) ? -diff : diff;
            stride = (mag * coeff + 65535) >>> 16;
            return (diff < 0) ? cur - stride : cur + stride;
        endfunction

        function longint scale_sample(longint s, longint g);
            longint y;
            y = (s * g + (longint'(1) <<< (GF - 1))) >>> GF;
            if (y > S_MAX)
                y = S_MAX;
            if (y < S_MIN)
                y = S_MIN;
            return y;
        endfunction

        function longint snap_gain(longint cur, longint tgt);
            if (tgt - cur <= SNAP_LSB && tgt - cur >= -SNAP_LSB)
                return tgt;
            return cur;
        endfunction

        function void take_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                 logic last_in);
            longint b;
            longint tl;
            longint tr;
            longint lo;
            longint ro;
            longint pk;
            longint mr;
            frame_result_t res;
            b = balance;
            if (b > BAL_POS)
                b = BAL_POS;
            if (b < BAL_NEG)
                b = BAL_NEG;
            tl = target_gain((b > 0) ? FACTOR_ONE - b : FACTOR_ONE);
            tr = target_gain((b < 0) ? FACTOR_ONE + b : FACTOR_ONE);
            left_gain = step_toward(left_gain, tl);
            right_gain = step_toward(right_gain, tr);
            lo = scale_sample(l, left_gain);
            ro = scale_sample(r, right_gain);
            if (mono)
            begin
                lo = (lo + ro) >>> 1;
                ro = 0;
                pk = (lo < 0) ? -lo : lo;
            end
            else
            begin
                pk = (lo < 0) ? -lo : lo;
                mr = (ro < 0) ? -ro : ro;
                if (mr > pk)
                    pk = mr;
            end
            if (pk > peak_acc)
                peak_acc = pk;
            res.peak = '0;
            res.closed = last_in;
            if (last_in)
            begin
                left_gain = snap_gain(left_gain, tl);
                right_gain = snap_gain(right_gain, tr);
                res.peak = PEAK_W'(peak_acc);
                peak_acc = 0;
                buffer_count = buffer_count + 1;
            end
            res.left_out = SW'(lo);
            res.right_out = SW'(ro);
            res.count = buffer_count;
            pending_frames.push_back(res);
        endfunction

        function void match(string field, logic signed [63:0] want, logic signed [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                  logic closed, logic [PEAK_W-1:0] peak,
                                  logic [COUNT_W-1:0] count);
            frame_result_t want;
            if (pending_frames.size() == 0)
            begin
                errors++;
                $display("%0t: result item with no frame pending, expected none actual %0d %0d",
                         $time, l, r);
                return;
            end
            want = pending_frames.pop_front();
            match("left_out", want.left_out, l);
            match("right_out", want.right_out, r);
            match("buffer_end", want.closed, closed);
            match("peak_level", want.peak, peak);
            match("buffers_completed", want.count, count);
        endfunction

        function int frames_in_flight();
            return pending_frames.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [SW-1:0]    left_sample = '0;
    logic signed [SW-1:0]    right_sample = '0;
    logic                    last_in_buffer = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [SW-1:0]    left_out;
    logic signed [SW-1:0]    right_out;
    logic                    buffer_end;
    logic [PEAK_W-1:0]       peak_level;
    logic [COUNT_W-1:0]      buffers_completed;

    balance_scoreboard sb = new();
    bit long_stall_req = 1'b0;
    int burst_left = 10;

    stereo_gain_balance_smoother_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .left_sample      (left_sample),
        .right_sample     (right_sample),
        .last_in_buffer   (last_in_buffer),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_out         (left_out),
        .right_out        (right_out),
        .buffer_end       (buffer_end),
        .peak_level       (peak_level),
        .buffers_completed(buffers_completed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.take_frame(left_sample, right_sample, last_in_buffer);
            if (out_valid && out_ready)
                sb.check_frame(left_out, right_out, buffer_end, peak_level, buffers_completed);
        end
    end

    initial
    begin
        int slot;
        logic [31:0] pattern;
        rx_mode_t mode;
        slot = 0;
        pattern = '1;
        mode = RX_ALWAYS;
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
                long_stall_req = 1'b0;
            end
            else
            begin
                if (slot == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    pattern = $urandom;
                end
                case (mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_PATTERN: out_ready <= pattern[slot];
                    RX_SPARSE:  out_ready <= pattern[slot] & 1'($urandom_range(0, 1));
                    default:    out_ready <= pattern[slot] | 1'($urandom_range(0, 1));
                endcase
                slot = (slot + 1) % 32;
            end
        end
    end

    task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                              input logic lst);
        int gap;
        in_valid <= 1'b1;
        left_sample <= l;
        right_sample <= r;
        last_in_buffer <= lst;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [GAIN_LEVEL_W-1:0] gain,
                                input logic signed [BALANCE_W-1:0] bal,
                                input logic mute_v, input logic mono_v,
                                input logic [COEFF_W-1:0] coeff_v);
        write_reg(REG_GAIN_LEVEL, gain);
        write_reg(REG_BALANCE, {1'b0, bal});
        write_reg(REG_MUTE, CFG_DATA_W'(mute_v));
        write_reg(REG_MONO_MIX, CFG_DATA_W'(mono_v));
        write_reg(REG_COEFF, CFG_DATA_W'(coeff_v));
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.frames_in_flight() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SW'($signed($urandom_range(0, 16)) - 8);
            default: return SW'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [GAIN_LEVEL_W-1:0] gain;
        logic signed [BALANCE_W-1:0] bal;
        logic [COEFF_W-1:0] coeff_v;
        int last_odds;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: both gains fade in from zero.
        send_frame(S_MAX, S_MIN, 1'b0);
        send_frame(-1, 1, 1'b1);
        drain();

        // Largest gain with a fast step drives both channels into saturation.
        program_regs(GAIN_MAX, '0, 1'b0, 1'b0, '1);
        send_frame(S_MAX, S_MIN, 1'b0);
        send_frame(S_MAX, S_MIN, 1'b0);
        send_frame(3, -3, 1'b0);
        send_frame(-1, 1, 1'b1);
        drain();

        // Gain and balance above their ranges, mono average rounded down.
        program_regs('1, 16'sh7FFF, 1'b0, 1'b1, '1);
        send_frame(S_MAX, S_MAX, 1'b0);
        send_frame(S_MIN, S_MIN, 1'b0);
        send_frame(-3, 0, 1'b1);
        drain();

        // Half gain on the left only, so odd samples land on rounding ties.
        program_regs(GAIN_LEVEL_RST >> 1, 16'sh8000, 1'b0, 1'b0, '1);
        send_frame(1, -1, 1'b0);
        send_frame(3, -3, 1'b0);
        send_frame(-1, 1, 1'b0);
        send_frame(S_MAX, S_MIN, 1'b1);
        drain();

        // A zero step freezes the gains even under mute.
        program_regs('0, '0, 1'b1, 1'b1, '0);
        send_frame(5, -7, 1'b0);
        send_frame(S_MIN, S_MAX, 1'b1);
        send_frame(0, 0, 1'b1);
        drain();

        // The slowest nonzero step, with every frame closing a buffer so that the snap is tried each time.
        program_regs(GAIN_LEVEL_RST, 16'sd1, 1'b0, 1'b0, 16'd1);
        send_frame(S_MAX, S_MAX, 1'b1);
        send_frame(S_MIN, 12345, 1'b1);
        send_frame(-2, 2, 1'b1);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            case ($urandom_range(0, 7))
                0:       gain = '0;
                1:       gain = GAIN_MAX;
                2:       gain = GAIN_LEVEL_W'($urandom);
                default: gain = GAIN_LEVEL_W'($urandom_range(0, GAIN_MAX));
            endcase
            case ($urandom_range(0, 5))
                0:       bal = BAL_POS;
                1:       bal = BAL_NEG;
                2:       bal = BALANCE_W'($urandom);
                default: bal = BALANCE_W'($signed($urandom_range(0, 32768)) - 16384);
            endcase
            case ($urandom_range(0, 6))
                0:       coeff_v = '0;
                1:       coeff_v = '1;
                2:       coeff_v = COEFF_W'($urandom_range(1, 300));
                default: coeff_v = COEFF_W'($urandom);
            endcase
            program_regs(gain, bal, $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)),
                         coeff_v);
            last_odds = (p % 3 == 0) ? 1 : $urandom_range(2, 16);
            for (int i = 0; i < 80; i++)
            begin
                if (p == 3 && i == 20)
                    long_stall_req = 1'b1;
                send_frame(pick_sample(), pick_sample(), $urandom_range(1, last_odds) == 1);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("PASS stereo_gain_balance_smoother_core");
        else
            $display("FAIL stereo_gain_balance_smoother_core");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL stereo_gain_balance_smoother_core");
        $finish;
    end

endmodule

// ===== stereo_gain_balance_smoother_core.f =====
+incdir+rtl
rtl/sgbs_pkg.sv
rtl/sgbs_lane.sv
rtl/sgbs_merge.sv
rtl/stereo_gain_balance_smoother_core.sv
sim/stereo_gain_balance_smoother_core_test.sv
